// File: hdl/vcte_pkg.sv
// Shared types, constants and key tables for the Vorbis comment tag extractor.
// No dependencies; every other file of the block imports this package.
package vcte_pkg;

    localparam int unsigned VCTE_MAX_COMMENTS = 1024;

    localparam int unsigned BODY_W  = 24;
    localparam int unsigned COUNT_W = 11;

    localparam logic [7:0] CH_EQ       = "=";
    localparam logic [7:0] CH_UPPER_A  = "A";
    localparam logic [7:0] CH_UPPER_Z  = "Z";
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    localparam logic [1:0] TAG_TITLE  = 2'd0;
    localparam logic [1:0] TAG_ARTIST = 2'd1;
    localparam logic [1:0] TAG_ALBUM  = 2'd2;

    typedef struct packed {
        logic [1:0] tag_kind;
        logic [7:0] value_byte;
        logic       value_last;
        logic       value_empty;
    } t_result;

    // Key length in characters.
    function automatic logic [2:0] key_len(input logic [1:0] tag);
        logic [2:0] len;
        case (tag)
            TAG_TITLE:  len = 3'd5;
            TAG_ARTIST: len = 3'd6;
            TAG_ALBUM:  len = 3'd5;
            default:    len = 3'd0;
        endcase
        return len;
    endfunction

    // Lower-case key character at a position; zero past the end of the key.
    function automatic logic [7:0] key_char(input logic [1:0] tag, input logic [2:0] pos);
        logic [7:0] ch;
        case ({tag, pos})
            {TAG_TITLE, 3'd0}:  ch = "t";
            {TAG_TITLE, 3'd1}:  ch = "i";
            {TAG_TITLE, 3'd2}:  ch = "t";
            {TAG_TITLE, 3'd3}:  ch = "l";
            {TAG_TITLE, 3'd4}:  ch = "e";
            {TAG_ARTIST, 3'd0}: ch = "a";
            {TAG_ARTIST, 3'd1}: ch = "r";
            {TAG_ARTIST, 3'd2}: ch = "t";
            {TAG_ARTIST, 3'd3}: ch = "i";
            {TAG_ARTIST, 3'd4}: ch = "s";
            {TAG_ARTIST, 3'd5}: ch = "t";
            {TAG_ALBUM, 3'd0}:  ch = "a";
            {TAG_ALBUM, 3'd1}:  ch = "l";
            {TAG_ALBUM, 3'd2}:  ch = "b";
            {TAG_ALBUM, 3'd3}:  ch = "u";
            {TAG_ALBUM, 3'd4}:  ch = "m";
            default:            ch = 8'd0;
        endcase
        return ch;
    endfunction

endpackage

// File: hdl/vcte_parser.sv
// Parse state and per-byte next-state logic of the comment tag extractor.
// Depends on vcte_pkg for widths, key tables and the result type.
module vcte_parser
    import vcte_pkg::*;
#(
    parameter int unsigned MAX_COMMENTS = VCTE_MAX_COMMENTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_block_start,
    input  logic [BODY_W-1:0] i_body_length,
    input  logic [7:0]        i_data_byte,
    output logic              o_res_valid,
    output t_result           o_res
);

    localparam logic [2:0] PH_STOPPED     = 3'd0;
    localparam logic [2:0] PH_VENDOR_LEN  = 3'd1;
    localparam logic [2:0] PH_VENDOR_SKIP = 3'd2;
    localparam logic [2:0] PH_COUNT       = 3'd3;
    localparam logic [2:0] PH_ENTRY_LEN   = 3'd4;
    localparam logic [2:0] PH_KEY         = 3'd5;
    localparam logic [2:0] PH_VALUE       = 3'd6;
    localparam logic [2:0] PH_SKIP        = 3'd7;

    localparam logic [31:0] MAX_COUNT = 32'(MAX_COMMENTS);

    logic [2:0]         r_phase, n_phase, e_phase;
    logic [1:0]         r_idx, n_idx, e_idx;
    logic [23:0]        r_acc, n_acc, e_acc;
    logic [BODY_W-1:0]  r_body, n_body, e_body;
    logic [COUNT_W-1:0] r_cl, n_cl, e_cl;
    logic [BODY_W-1:0]  r_entry, n_entry, e_entry;
    logic [2:0]         r_kpos, n_kpos, e_kpos;
    logic [2:0]         r_kmatch, n_kmatch, e_kmatch;
    logic [1:0]         r_tag, n_tag, e_tag;
    logic [2:0]         r_seen, n_seen, e_seen;

    logic [BODY_W-1:0]  left;
    logic [BODY_W-1:0]  entry_dec;
    logic [COUNT_W-1:0] cl_dec;
    logic [31:0]        full;
    logic [7:0]         folded;
    logic [2:0]         cand;
    logic [2:0]         keep;
    logic [1:0]         hit_k;
    logic               do_end;
    logic               emit;
    t_result            res;

    always_comb begin
        folded = i_data_byte;
        if (i_data_byte >= CH_UPPER_A && i_data_byte <= CH_UPPER_Z) begin
            folded = i_data_byte + CASE_OFFSET;
        end
    end

    always_comb begin
        e_phase  = r_phase;
        e_idx    = r_idx;
        e_acc    = r_acc;
        e_body   = r_body;
        e_cl     = r_cl;
        e_entry  = r_entry;
        e_kpos   = r_kpos;
        e_kmatch = r_kmatch;
        e_tag    = r_tag;
        e_seen   = r_seen;
        // A new body restarts everything before this byte is parsed.
        if (i_block_start) begin
            e_phase  = (i_body_length >= BODY_W'(8)) ? PH_VENDOR_LEN : PH_STOPPED;
            e_idx    = 2'd0;
            e_acc    = 24'd0;
            e_body   = i_body_length;
            e_cl     = '0;
            e_entry  = '0;
            e_kpos   = 3'd0;
            e_kmatch = 3'b111;
            e_tag    = TAG_TITLE;
            e_seen   = 3'b000;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cand[k] = e_kmatch[k] && (e_kpos == key_len(2'(k))) && !e_seen[k];
            keep[k] = (e_kpos < key_len(2'(k))) && (key_char(2'(k), e_kpos) == folded);
        end
        if (cand[0]) begin
            hit_k = TAG_TITLE;
        end else if (cand[1]) begin
            hit_k = TAG_ARTIST;
        end else begin
            hit_k = TAG_ALBUM;
        end
    end

    always_comb begin
        n_phase  = e_phase;
        n_idx    = e_idx;
        n_acc    = e_acc;
        n_body   = e_body;
        n_cl     = e_cl;
        n_entry  = e_entry;
        n_kpos   = e_kpos;
        n_kmatch = e_kmatch;
        n_tag    = e_tag;
        n_seen   = e_seen;
        do_end   = 1'b0;
        emit     = 1'b0;
        res      = '{tag_kind: e_tag, value_byte: i_data_byte, value_last: 1'b0,
                     value_empty: 1'b0};
        left      = e_body - BODY_W'(1);
        entry_dec = e_entry - BODY_W'(1);
        cl_dec    = e_cl - COUNT_W'(1);
        full      = {i_data_byte, e_acc};

        if (e_phase != PH_STOPPED) begin
            if (e_body == '0) begin
                n_phase = PH_STOPPED;
            end else begin
                n_body = left;
                case (e_phase)
                    PH_VENDOR_LEN, PH_COUNT, PH_ENTRY_LEN: begin
                        if (e_idx != 2'd3) begin
                            n_acc = e_acc | (24'(i_data_byte) << {e_idx, 3'b000});
                            n_idx = e_idx + 2'd1;
                        end else begin
                            n_idx = 2'd0;
                            if (e_phase == PH_COUNT) begin
                                if (full > MAX_COUNT || full == 32'd0) begin
                                    n_phase = PH_STOPPED;
                                end else begin
                                    n_cl    = full[COUNT_W-1:0];
                                    n_phase = PH_ENTRY_LEN;
                                    n_acc   = 24'd0;
                                end
                            end else if (full > {8'd0, left}) begin
                                n_phase = PH_STOPPED;
                            end else begin
                                n_entry = full[BODY_W-1:0];
                                if (e_phase == PH_VENDOR_LEN) begin
                                    if (full == 32'd0) begin
                                        n_phase = PH_COUNT;
                                        n_acc   = 24'd0;
                                    end else begin
                                        n_phase = PH_VENDOR_SKIP;
                                    end
                                end else if (full == 32'd0) begin
                                    do_end = 1'b1;
                                end else begin
                                    n_phase  = PH_KEY;
                                    n_kpos   = 3'd0;
                                    n_kmatch = 3'b111;
                                end
                            end
                        end
                    end
                    PH_VENDOR_SKIP: begin
                        n_entry = entry_dec;
                        if (entry_dec == '0) begin
                            n_phase = PH_COUNT;
                            n_idx   = 2'd0;
                            n_acc   = 24'd0;
                        end
                    end
                    PH_KEY: begin
                        n_entry = entry_dec;
                        if (i_data_byte == CH_EQ) begin
                            if (cand == 3'b000) begin
                                if (entry_dec == '0) begin
                                    do_end = 1'b1;
                                end else begin
                                    n_phase = PH_SKIP;
                                end
                            end else begin
                                n_tag  = hit_k;
                                n_seen = e_seen | (3'b001 << hit_k);
                                if (entry_dec == '0) begin
                                    // Empty value: one marker item on the '=' byte.
                                    emit   = 1'b1;
                                    res    = '{tag_kind: hit_k, value_byte: 8'd0,
                                               value_last: 1'b1, value_empty: 1'b1};
                                    do_end = 1'b1;
                                end else begin
                                    n_phase = PH_VALUE;
                                end
                            end
                        end else begin
                            n_kmatch = e_kmatch & keep;
                            if (e_kpos != 3'd7) begin
                                n_kpos = e_kpos + 3'd1;
                            end
                            if (entry_dec == '0) begin
                                do_end = 1'b1;
                            end
                        end
                    end
                    PH_VALUE: begin
                        n_entry        = entry_dec;
                        emit           = 1'b1;
                        res.value_last = (entry_dec == '0);
                        if (entry_dec == '0) begin
                            do_end = 1'b1;
                        end
                    end
                    PH_SKIP: begin
                        n_entry = entry_dec;
                        if (entry_dec == '0) begin
                            do_end = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_STOPPED;
                    end
                endcase

                // Close the comment: advance to the next length or stop after the last.
                if (do_end) begin
                    n_cl = cl_dec;
                    if (cl_dec == '0) begin
                        n_phase = PH_STOPPED;
                    end else begin
                        n_phase = PH_ENTRY_LEN;
                        n_idx   = 2'd0;
                        n_acc   = 24'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_STOPPED;
            r_idx    <= 2'd0;
            r_acc    <= 24'd0;
            r_body   <= '0;
            r_cl     <= '0;
            r_entry  <= '0;
            r_kpos   <= 3'd0;
            r_kmatch <= 3'b111;
            r_tag    <= TAG_TITLE;
            r_seen   <= 3'b000;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_acc    <= n_acc;
            r_body   <= n_body;
            r_cl     <= n_cl;
            r_entry  <= n_entry;
            r_kpos   <= n_kpos;
            r_kmatch <= n_kmatch;
            r_tag    <= n_tag;
            r_seen   <= n_seen;
        end
    end

    assign o_res_valid = i_accept && emit;
    assign o_res       = res;

    a_emit_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !i_block_start && (r_phase == PH_KEY || r_phase == PH_VALUE))
        else $error("result produced outside key or value phase");

    a_value_tag_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && r_phase == PH_VALUE) |-> r_seen[r_tag])
        else $error("value byte emitted for a tag not marked seen");

    a_seen_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && !i_block_start) |=> ((r_seen & $past(r_seen)) == $past(r_seen)))
        else $error("seen tags cleared without a new body");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.value_empty) |-> (o_res.value_last && r_phase == PH_KEY))
        else $error("empty value item malformed");

endmodule

// File: hdl/vcte_out_reg.sv
// Output register with a one-entry skid stage for the tag extractor results.
// Depends on vcte_pkg for the result type.
module vcte_out_reg
    import vcte_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_res,
    output logic    o_full
);

    logic    r_m_valid, r_s_valid;
    t_result r_m, r_s;
    logic    drain;

    assign drain = r_m_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else begin
            if (r_s_valid) begin
                // Upstream is held while the skid is full; move skid into main on transfer.
                if (drain) begin
                    r_m_valid <= 1'b1;
                    r_s_valid <= 1'b0;
                end
            end else if (i_load) begin
                if (!r_m_valid || drain) begin
                    r_m_valid <= 1'b1;
                end else begin
                    r_s_valid <= 1'b1;
                end
            end else if (drain) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s_valid) begin
            if (drain) begin
                r_m <= r_s;
            end
        end else if (i_load) begin
            if (!r_m_valid || drain) begin
                r_m <= i_res;
            end else begin
                r_s <= i_res;
            end
        end
    end

    assign o_valid = r_m_valid;
    assign o_res   = r_m;
    assign o_full  = r_s_valid;

    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s_valid |-> r_m_valid)
        else $error("skid holds a result while main register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_s_valid && i_load && r_m_valid && i_stall) |=> r_s_valid)
        else $error("result lost while output stalled");

    a_skid_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s_valid && drain) |=> (r_m_valid && !r_s_valid))
        else $error("skid result not moved to main register");

endmodule

// File: hdl/vorbis_comment_tag_extractor_core.sv
// Vorbis comment tag extractor: streams a comment block body byte by byte and
// emits the title, artist and album value bytes.
// Input channel (i_valid / o_stall): one body byte per transfer; i_block_start
// marks the first byte of a body and samples i_body_length with it.
// Output channel (o_valid / i_stall): one value byte per transfer, tagged by
// o_tag_kind, with o_value_last on the final byte and o_value_empty for a
// key whose value is empty (then o_value_byte is zero).
// Throughput: one byte per cycle while o_stall is low, set by the single parse-state update per byte.
// Results: each result is registered in the output register, or in the skid stage while the output stalls.
// Stalls: a skid stage holds one result behind the output register; o_stall
// rises only when that skid entry is occupied, so bytes keep flowing while the
// receiver stalls until a second result is waiting behind the held one.
// Reset (synchronous, active low): parse stops and all results are dropped;
// bytes are ignored until the next i_block_start.
// Values appear in stream order; only the first occurrence of each key is sent.
module vorbis_comment_tag_extractor_core
    import vcte_pkg::*;
#(
    parameter int unsigned MAX_COMMENTS = VCTE_MAX_COMMENTS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_block_start,
    input  logic [BODY_W-1:0] i_body_length,
    input  logic [7:0]        i_data_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_tag_kind,
    output logic [7:0]        o_value_byte,
    output logic              o_value_last,
    output logic              o_value_empty
);

    logic    in_accept;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    skid_full;

    assign o_stall   = skid_full;
    assign in_accept = i_valid && !skid_full;

    vcte_parser #(
        .MAX_COMMENTS(MAX_COMMENTS)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_block_start(i_block_start),
        .i_body_length(i_body_length),
        .i_data_byte  (i_data_byte),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    vcte_out_reg u_out_reg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (res_valid),
        .i_res  (res),
        .i_stall(i_stall),
        .o_valid(o_valid),
        .o_res  (out_res),
        .o_full (skid_full)
    );

    assign o_tag_kind    = out_res.tag_kind;
    assign o_value_byte  = out_res.value_byte;
    assign o_value_last  = out_res.value_last;
    assign o_value_empty = out_res.value_empty;

endmodule

// File: sim/vorbis_comment_tag_extractor_core_test.sv
// Self-checking testbench for vorbis_comment_tag_extractor_core: random comment bodies in,
// tagged value bytes out, checked in order against a byte-level parse tracker.
// Depends on vcte_pkg and the core only.
`timescale 1ns / 100ps

module vorbis_comment_tag_extractor_core_test
    import vcte_pkg::*;
();

    // Parse tracker: follows the body parse byte by byte and queues the value bytes it expects.
    class tag_value_tracker;
        typedef enum logic [2:0] {
            PH_STOPPED, PH_VENDOR_LEN, PH_VENDOR_SKIP, PH_COUNT,
            PH_ENTRY_LEN, PH_KEY, PH_VALUE, PH_SKIP
        } parse_phase_e;

        string        key_names[3];
        parse_phase_e phase;
        logic [1:0]   field_idx;
        logic [31:0]  len_acc;
        logic [23:0]  body_left;
        logic [10:0]  comments_left;
        logic [23:0]  entry_left;
        logic [2:0]   key_pos;
        logic [2:0]   key_hits;
        logic [1:0]   cur_tag;
        logic [2:0]   tags_seen;
        t_result      expected_values[$];
        int           mismatch_count;

        function new();
            key_names = '{"title", "artist", "album"};
            mismatch_count = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            phase         = PH_STOPPED;
            field_idx     = '0;
            len_acc       = '0;
            body_left     = '0;
            comments_left = '0;
            entry_left    = '0;
            key_pos       = '0;
            key_hits      = '1;
            cur_tag       = '0;
            tags_seen     = '0;
        endfunction

        function void open_field(parse_phase_e next);
            phase     = next;
            field_idx = '0;
            len_acc   = '0;
        endfunction

        function void close_comment();
            comments_left = comments_left - 11'd1;
            if (comments_left == 0) phase = PH_STOPPED;
            else open_field(PH_ENTRY_LEN);
        endfunction

        function void add_value(logic [7:0] vb, bit last, bit empty);
            t_result r;
            r.tag_kind    = cur_tag;
            r.value_byte  = empty ? 8'd0 : vb;
            r.value_last  = last;
            r.value_empty = empty;
            expected_values.push_back(r);
        endfunction

        function int pending();
            return expected_values.size();
        endfunction

        // Advance the parse by one transferred body byte.
        function void take_body_byte(bit start, logic [23:0] blen, logic [7:0] b);
            logic [23:0] bytes_left;
            logic [7:0]  folded;
            int          hit;
            if (start) begin
                clear_parse();
                body_left = blen;
                if (blen >= 24'd8) open_field(PH_VENDOR_LEN);
            end
            if (phase == PH_STOPPED) return;
            if (body_left == 0) begin
                phase = PH_STOPPED;
                return;
            end
            body_left  = body_left - 24'd1;
            bytes_left = body_left;

            case (phase)
                PH_VENDOR_LEN, PH_COUNT, PH_ENTRY_LEN: begin
                    len_acc = len_acc | ({24'd0, b} << (8 * field_idx));
                    if (field_idx != 2'd3) begin
                        field_idx = field_idx + 2'd1;
                        return;
                    end
                    field_idx = '0;
                    if (phase == PH_COUNT) begin
                        if (len_acc > VCTE_MAX_COMMENTS || len_acc == 0) begin
                            phase = PH_STOPPED;
                            return;
                        end
                        comments_left = len_acc[10:0];
                        open_field(PH_ENTRY_LEN);
                        return;
                    end
                    if (len_acc > {8'd0, bytes_left}) begin
                        phase = PH_STOPPED;
                        return;
                    end
                    entry_left = len_acc[23:0];
                    if (phase == PH_VENDOR_LEN) begin
                        if (entry_left == 0) open_field(PH_COUNT);
                        else phase = PH_VENDOR_SKIP;
                    end else if (entry_left == 0) begin
                        close_comment();
                    end else begin
                        phase    = PH_KEY;
                        key_pos  = '0;
                        key_hits = '1;
                    end
                end
                PH_VENDOR_SKIP: begin
                    entry_left = entry_left - 24'd1;
                    if (entry_left == 0) open_field(PH_COUNT);
                end
                PH_KEY: begin
                    entry_left = entry_left - 24'd1;
                    if (b == CH_EQ) begin
                        hit = -1;
                        for (int k = 0; k < 3; k++)
                            if (hit < 0 && key_hits[k] && key_pos == key_names[k].len()
                                && !tags_seen[k])
                                hit = k;
                        if (hit < 0) begin
                            if (entry_left == 0) close_comment();
                            else phase = PH_SKIP;
                            return;
                        end
                        cur_tag        = 2'(hit);
                        tags_seen[hit] = 1'b1;
                        if (entry_left == 0) begin
                            add_value(8'd0, 1'b1, 1'b1);
                            close_comment();
                            return;
                        end
                        phase = PH_VALUE;
                    end else begin
                        folded = (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + CASE_OFFSET : b;
                        for (int k = 0; k < 3; k++)
                            if (key_pos >= key_names[k].len()
                                || key_names[k][key_pos] != folded)
                                key_hits[k] = 1'b0;
                        if (key_pos != 3'd7) key_pos = key_pos + 3'd1;
                        if (entry_left == 0) close_comment();
                    end
                end
                PH_VALUE: begin
                    entry_left = entry_left - 24'd1;
                    add_value(b, entry_left == 0, 1'b0);
                    if (entry_left == 0) close_comment();
                end
                PH_SKIP: begin
                    entry_left = entry_left - 24'd1;
                    if (entry_left == 0) close_comment();
                end
                default: phase = PH_STOPPED;
            endcase
        endfunction

        function void check_value(t_result got);
            t_result want;
            if (expected_values.size() == 0) begin
                $error("unexpected value transfer: tag_kind %0d value_byte %0h last %0b empty %0b",
                       got.tag_kind, got.value_byte, got.value_last, got.value_empty);
                mismatch_count++;
                return;
            end
            want = expected_values.pop_front();
            if (got.tag_kind !== want.tag_kind) begin
                $error("tag_kind: expected %0d, actual %0d", want.tag_kind, got.tag_kind);
                mismatch_count++;
            end
            if (got.value_byte !== want.value_byte) begin
                $error("value_byte: expected %0h, actual %0h", want.value_byte, got.value_byte);
                mismatch_count++;
            end
            if (got.value_last !== want.value_last) begin
                $error("value_last: expected %0b, actual %0b", want.value_last, got.value_last);
                mismatch_count++;
            end
            if (got.value_empty !== want.value_empty) begin
                $error("value_empty: expected %0b, actual %0b",
                       want.value_empty, got.value_empty);
                mismatch_count++;
            end
        endfunction
    endclass

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int          HOLD_CYCLES = 250;
    localparam int          PHASE_BYTES = 360;

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              i_valid       = 1'b0;
    logic              i_block_start = 1'b0;
    logic [BODY_W-1:0] i_body_length = '0;
    logic [7:0]        i_data_byte   = '0;
    logic              i_stall       = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic [1:0]        o_tag_kind;
    logic [7:0]        o_value_byte;
    logic              o_value_last;
    logic              o_value_empty;

    tag_value_tracker tracker = new();
    string            key_names[3] = '{"title", "artist", "album"};

    int          src_idle_pct    = 22;
    int          dst_idle_pct    = 53;
    int          hold_requests   = 0;
    int          holds_done      = 0;
    int          hold_left       = 0;
    int          body_bytes_sent = 0;
    int unsigned cycle_count     = 0;

    vorbis_comment_tag_extractor_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_block_start (i_block_start),
        .i_body_length (i_body_length),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_tag_kind    (o_tag_kind),
        .o_value_byte  (o_value_byte),
        .o_value_last  (o_value_last),
        .o_value_empty (o_value_empty)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: check each value transfer, stall at random, serve long hold-offs on request.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            tracker.check_value({o_tag_kind, o_value_byte, o_value_last, o_value_empty});
        if (hold_left > 0) begin
            hold_left--;
        end else if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
        end
        i_stall <= (hold_left > 0) || ($urandom_range(0, 99) < dst_idle_pct);
    end

    // Offer one body byte and hold it until the transfer.
    task automatic send_byte(input bit start, input logic [23:0] blen, input logic [7:0] data);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_block_start <= start;
        i_body_length <= blen;
        i_data_byte   <= data;
        do @(posedge i_clk); while (o_stall);
        tracker.take_body_byte(start, blen, data);
    endtask

    task automatic send_body(ref logic [7:0] q[$], input logic [23:0] blen);
        foreach (q[i]) send_byte(i == 0, (i == 0) ? blen : 24'($urandom), q[i]);
        body_bytes_sent += q.size();
    endtask

    task automatic pause_until_drained();
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic void put_le32(ref logic [7:0] q[$], input logic [31:0] v);
        for (int i = 0; i < 4; i++) q.push_back(v[8*i +: 8]);
    endfunction

    function automatic void set_le32(ref logic [7:0] q[$], input int at, input logic [31:0] v);
        for (int i = 0; i < 4; i++) q[at + i] = v[8*i +: 8];
    endfunction

    function automatic void put_text(ref logic [7:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    endfunction

    function automatic void put_comment(ref logic [7:0] q[$], input string s);
        put_le32(q, s.len());
        put_text(q, s);
    endfunction

    // One comment: mostly wanted keys in mixed case, plus near misses, junk keys,
    // empty keys, keys without '=' and zero-length comments.
    function automatic void build_comment(ref logic [7:0] c[$], input bit long_value);
        int         kind;
        int         k;
        int         vlen;
        logic [7:0] ch;
        c.delete();
        kind = $urandom_range(0, 11);
        k    = $urandom_range(0, 2);
        if (kind <= 6 || kind == 10) begin
            for (int i = 0; i < key_names[k].len(); i++) begin
                ch = key_names[k][i];
                if ($urandom_range(0, 1)) ch = ch - CASE_OFFSET;
                c.push_back(ch);
            end
            if (kind == 6) begin
                case ($urandom_range(0, 3))
                    0: void'(c.pop_back());
                    1: c.push_back(8'h00);
                    2: c.insert($urandom_range(0, c.size() - 1), 8'h00);
                    default: begin
                        k    = $urandom_range(0, c.size() - 1);
                        c[k] = c[k] ^ 8'h80;
                    end
                endcase
            end
        end else if (kind == 7 || kind == 8) begin
            repeat ($urandom_range(1, 9)) begin
                ch = 8'($urandom);
                if (ch == CH_EQ) ch = CH_UPPER_Z;
                c.push_back(ch);
            end
        end
        if (kind == 11) begin
            c.delete();
        end else if (kind != 10) begin
            c.push_back(CH_EQ);
            if (long_value) vlen = $urandom_range(16, 40);
            else if ($urandom_range(0, 3) == 0) vlen = 0;
            else vlen = $urandom_range(1, 10);
            repeat (vlen) c.push_back(8'($urandom));
        end
    endfunction

    function automatic void build_body(ref logic [7:0] q[$], input bit long_values,
                                       output int count_at);
        logic [7:0] c[$];
        int         vendor_bytes;
        int         n;
        q.delete();
        vendor_bytes = $urandom_range(0, 6);
        put_le32(q, vendor_bytes);
        repeat (vendor_bytes) q.push_back(8'($urandom));
        count_at = q.size();
        n = $urandom_range(1, 6);
        put_le32(q, n);
        repeat (n) begin
            build_comment(c, long_values);
            put_le32(q, c.size());
            foreach (c[i]) q.push_back(c[i]);
        end
    endfunction

    task automatic send_good_body(input bit long_values);
        logic [7:0]  q[$];
        logic [23:0] blen;
        int          count_at;
        build_body(q, long_values, count_at);
        blen = 24'(q.size());
        case ($urandom_range(0, 9))
            0: blen = blen + 24'($urandom_range(1, 20));
            1: blen = 24'hFFFFFF;
            default: ;
        endcase
        // trailing bytes after the last comment
        if (blen != q.size()) repeat ($urandom_range(1, 6)) q.push_back(8'($urandom));
        send_body(q, blen);
    endtask

    task automatic send_broken_body();
        logic [7:0]  q[$];
        logic [23:0] blen;
        logic [31:0] cnt;
        int          count_at;
        build_body(q, 1'b0, count_at);
        blen = 24'(q.size());
        case ($urandom_range(0, 6))
            0: blen = 24'($urandom_range(0, q.size() - 1));
            1: q[3] = 8'($urandom_range(1, 255));
            2: begin
                case ($urandom_range(0, 4))
                    0: cnt = 0;
                    1: cnt = VCTE_MAX_COMMENTS;
                    2: cnt = VCTE_MAX_COMMENTS + 1;
                    3: cnt = 32'h800;
                    default: cnt = $urandom;
                endcase
                set_le32(q, count_at, cnt);
            end
            3: q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
            // cut short: the next body restarts the parse mid-stream
            4: q = q[0:$urandom_range(0, q.size() - 1)];
            5: repeat ($urandom_range(1, 4)) send_byte(1'b0, 24'($urandom), 8'($urandom));
            default: set_le32(q, count_at + 4,
                              q.size() - (count_at + 8) + $urandom_range(1, 3));
        endcase
        send_body(q, blen);
    endtask

    task automatic run_directed_cases();
        logic [7:0] q[$];
        // short body
        q = '{8'h00, 8'h00, 8'h00};
        send_body(q, 24'd7);
        // wanted keys in mixed case, empty value, repeat, empty key, zero byte in key,
        // key without '=', zero-length comment, trailing bytes
        q.delete();
        put_le32(q, 1);
        put_text(q, "v");
        put_le32(q, 8);
        put_comment(q, "TITLE=");
        put_comment(q, "ArTiSt=xy");
        put_comment(q, "album=Z");
        put_comment(q, "title=again");
        put_comment(q, "=v");
        put_le32(q, 8);
        put_text(q, "title");
        q.push_back(8'h00);
        put_text(q, "=q");
        put_comment(q, "noequals");
        put_le32(q, 0);
        put_text(q, "zz");
        send_body(q, 24'(q.size()));
        // vendor overrun
        q.delete();
        put_le32(q, 32'hFFFFFFFF);
        put_le32(q, 1);
        send_body(q, 24'hFFFFFF);
        // too many comments
        q.delete();
        put_le32(q, 0);
        put_le32(q, VCTE_MAX_COMMENTS + 1);
        put_comment(q, "title=x");
        send_body(q, 24'(q.size()));
        // largest count accepted, body ends inside the next length field
        q.delete();
        put_le32(q, 0);
        put_le32(q, VCTE_MAX_COMMENTS);
        put_comment(q, "album=ab");
        q.push_back(8'h05);
        q.push_back(8'h00);
        send_body(q, 24'(q.size()));
        // comment overrun
        q.delete();
        put_le32(q, 0);
        put_le32(q, 1);
        put_le32(q, 100);
        put_text(q, "artist=overrun");
        send_body(q, 24'(q.size()));
        // bytes while stopped
        repeat (3) send_byte(1'b0, 24'($urandom), 8'($urandom));
    endtask

    initial begin
        int src_pct[3];
        int dst_pct[3];
        int phase_start;
        bit held;
        src_pct = '{22, 53, 0};
        dst_pct = '{53, 22, 0};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed_cases();
        pause_until_drained();

        for (int p = 0; p < 3; p++) begin
            src_idle_pct = src_pct[p];
            dst_idle_pct = dst_pct[p];
            phase_start  = body_bytes_sent;
            held         = 1'b0;
            while (body_bytes_sent - phase_start < PHASE_BYTES) begin
                if (!held && body_bytes_sent - phase_start > 120) begin
                    // receiver holds off while long values keep coming
                    hold_requests++;
                    held = 1'b1;
                    send_good_body(1'b1);
                end else if ($urandom_range(0, 3) == 0) begin
                    send_broken_body();
                end else begin
                    send_good_body(1'b0);
                end
            end
            pause_until_drained();
        end

        if (tracker.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
hdl/vcte_pkg.sv
hdl/vcte_parser.sv
hdl/vcte_out_reg.sv
hdl/vorbis_comment_tag_extractor_core.sv
sim/vorbis_comment_tag_extractor_core_test.sv
